@@ rtl/core/fmppt_pkg.sv @@
package fmppt_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 30;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_MIN_VOLTAGE = csr_index_type'(0);
   localparam csr_index_type CSR_MAX_VOLTAGE = csr_index_type'(1);
   localparam csr_index_type CSR_MAX_POWER   = csr_index_type'(2);
   localparam csr_index_type CSR_MAX_CURRENT = csr_index_type'(3);

   // Register widths and reset values.
   localparam int MIN_VOLTAGE_BITS = 16;
   localparam int MAX_VOLTAGE_BITS = 16;
   localparam int MAX_POWER_BITS   = 30;
   localparam int MAX_CURRENT_BITS = 14;

   localparam logic [MIN_VOLTAGE_BITS-1:0] RESET_MIN_VOLTAGE = 16'd50;
   localparam logic [MAX_VOLTAGE_BITS-1:0] RESET_MAX_VOLTAGE = 16'd721;
   localparam logic [MAX_POWER_BITS-1:0]   RESET_MAX_POWER   = 30'd3630000;
   localparam logic [MAX_CURRENT_BITS-1:0] RESET_MAX_CURRENT = 14'd6150;

   // Result field widths.
   localparam int REF_BITS  = 17;
   localparam int PBIN_BITS = 3;
   localparam int IBIN_BITS = 2;
   localparam int STEP_BITS = 7;

   // Three times the largest power base, plus a sign bit.
   localparam int BASE_CMP_BITS = 33;

   // Margin below the voltage limit used by the clamp.
   localparam int CLAMP_MARGIN_MV = 10;

   // Power change classes.
   localparam logic [PBIN_BITS-1:0] PBIN_NEG_BIG   = 3'd0;
   localparam logic [PBIN_BITS-1:0] PBIN_NEG_SMALL = 3'd1;
   localparam logic [PBIN_BITS-1:0] PBIN_ZERO      = 3'd2;
   localparam logic [PBIN_BITS-1:0] PBIN_POS_SMALL = 3'd3;
   localparam logic [PBIN_BITS-1:0] PBIN_POS_BIG   = 3'd4;

   // Current change classes.
   localparam logic [IBIN_BITS-1:0] IBIN_NEG  = 2'd0;
   localparam logic [IBIN_BITS-1:0] IBIN_ZERO = 2'd1;
   localparam logic [IBIN_BITS-1:0] IBIN_POS  = 2'd2;

   // Voltage steps in millivolts.
   localparam logic signed [STEP_BITS-1:0] STEP_DOWN_BIG   = -7'sd40;
   localparam logic signed [STEP_BITS-1:0] STEP_DOWN_SMALL = -7'sd20;
   localparam logic signed [STEP_BITS-1:0] STEP_UP_TINY    = 7'sd10;
   localparam logic signed [STEP_BITS-1:0] STEP_UP_SMALL   = 7'sd20;
   localparam logic signed [STEP_BITS-1:0] STEP_UP_BIG     = 7'sd40;

   // Bit-serial comparator slots: each asks whether stream a exceeds stream b.
   localparam int CMP_COUNT       = 10;
   localparam int CMP_P_GT_NB     = 0;  // dP       > -Bp
   localparam int CMP_P10_GT_NB   = 1;  // 10*dP    > -Bp
   localparam int CMP_P100_GT_N3B = 2;  // 100*dP   > -3*Bp
   localparam int CMP_P100_GT_3B  = 3;  // 100*dP   > 3*Bp
   localparam int CMP_P10_GT_B    = 4;  // 10*dP    > Bp
   localparam int CMP_P_GT_B      = 5;  // dP       > Bp
   localparam int CMP_I_GT_NB     = 6;  // dI       > -Bi
   localparam int CMP_I100_GT_NB  = 7;  // 100*dI   > -Bi
   localparam int CMP_I100_GT_B   = 8;  // 100*dI   > Bi
   localparam int CMP_I_GT_B      = 9;  // dI       > Bi

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // Rule table: row is the current class, column the power class.
   function automatic logic signed [STEP_BITS-1:0] rule_step(
      input logic [IBIN_BITS-1:0] ibin,
      input logic [PBIN_BITS-1:0] pbin
   );
      logic signed [STEP_BITS-1:0] step;
      step = STEP_UP_SMALL;
      unique case (ibin)
         IBIN_NEG: begin
            unique case (pbin)
               PBIN_NEG_BIG, PBIN_NEG_SMALL, PBIN_ZERO: step = STEP_DOWN_SMALL;
               PBIN_POS_SMALL: step = STEP_UP_SMALL;
               PBIN_POS_BIG: step = STEP_UP_BIG;
               default: step = STEP_UP_TINY;
            endcase
         end
         IBIN_ZERO: begin
            unique case (pbin)
               PBIN_NEG_BIG, PBIN_NEG_SMALL, PBIN_POS_SMALL: step = STEP_UP_SMALL;
               PBIN_ZERO: step = STEP_UP_TINY;
               PBIN_POS_BIG: step = STEP_UP_BIG;
               default: step = STEP_UP_TINY;
            endcase
         end
         IBIN_POS: begin
            unique case (pbin)
               PBIN_NEG_BIG: step = STEP_UP_BIG;
               PBIN_NEG_SMALL, PBIN_ZERO: step = STEP_UP_SMALL;
               PBIN_POS_SMALL, PBIN_POS_BIG: step = STEP_DOWN_SMALL;
               default: step = STEP_UP_TINY;
            endcase
         end
         default: step = STEP_UP_TINY;
      endcase
      return step;
   endfunction

endpackage

@@ rtl/core/fuzzy_mppt_reference_step_core.sv @@
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_voltage_mv, req_current_ma
// rsp_      out        rsp_valid/stall    rsp_ref_voltage_mv, rsp_power_bin,
//                                         rsp_current_bin, rsp_first_sample
// csr_      in         csr_write_en       csr_index, csr_wdata
//
// One request passes an accept step, an N-bit serial pass with
// N = max(VOLTAGE_BITS + CURRENT_BITS + 8, 33) and a finish step that selects
// the classes, applies the rule step and clamps.
// In the bit-serial pass the product, the differences, the scaled
// terms and ten comparisons all advance one bit per cycle, LSB first.
// Reset is synchronous; only the control and configuration registers return to their reset values.
// A new request is accepted while a finished result still waits in the output
// register; the finish cycle waits only if that register is still occupied and stalled.
module fuzzy_mppt_reference_step_core #(
   parameter int VOLTAGE_BITS = 16,
   parameter int CURRENT_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [VOLTAGE_BITS-1:0]                 req_voltage_mv,
   input  logic [CURRENT_BITS-1:0]                 req_current_ma,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fmppt_pkg::REF_BITS-1:0]   rsp_ref_voltage_mv,
   output logic [fmppt_pkg::PBIN_BITS-1:0]         rsp_power_bin,
   output logic [fmppt_pkg::IBIN_BITS-1:0]         rsp_current_bin,
   output logic                                    rsp_first_sample,
   input  logic                                    csr_write_en,
   input  fmppt_pkg::csr_index_type                csr_index,
   input  logic [fmppt_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import fmppt_pkg::*;

   // Geometry of the serial pass.
   localparam int PW        = VOLTAGE_BITS + CURRENT_BITS;
   localparam int SCALED_W  = PW + 8;
   localparam int N         = (SCALED_W > BASE_CMP_BITS) ? SCALED_W : BASE_CMP_BITS;
   localparam int CW        = $clog2(N);
   localparam int HIST_BITS = 6;
   localparam int RW        = ((VOLTAGE_BITS > MIN_VOLTAGE_BITS) ?
                               VOLTAGE_BITS : MIN_VOLTAGE_BITS) + 2;

   localparam logic [CW-1:0] LAST_CNT = CW'(N - 1);
   localparam logic [CW-1:0] PW_CNT   = CW'(PW);
   localparam logic [CW-1:0] CB_CNT   = CW'(CURRENT_BITS);

   // Control registers.
   state_type                    state_ff, state_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         is_first_ff, is_first_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [MIN_VOLTAGE_BITS-1:0]  cfg_min_ff, cfg_min_in;
   logic [MAX_VOLTAGE_BITS-1:0]  cfg_max_ff, cfg_max_in;
   logic [MAX_POWER_BITS-1:0]    cfg_power_ff, cfg_power_in;
   logic [MAX_CURRENT_BITS-1:0]  cfg_current_ff, cfg_current_in;

   // Serial datapath registers.
   logic                         item_first_ff, item_first_in;
   logic [VOLTAGE_BITS-1:0]      v_ff, v_in;
   logic [VOLTAGE_BITS-1:0]      acc_ff, acc_in;
   logic [CURRENT_BITS-1:0]      c_sr_ff, c_sr_in;
   logic [PW-1:0]                prevp_sr_ff, prevp_sr_in;
   logic [CURRENT_BITS-1:0]      prevc_sr_ff, prevc_sr_in;
   logic [MAX_POWER_BITS-1:0]    bp_sr_ff, bp_sr_in;
   logic [MAX_CURRENT_BITS-1:0]  bi_sr_ff, bi_sr_in;
   logic                         bor_p_ff, bor_p_in;
   logic                         bor_i_ff, bor_i_in;
   logic [HIST_BITS-1:0]         dph_ff, dph_in;
   logic [HIST_BITS-1:0]         dih_ff, dih_in;
   logic [1:0]                   c100p_ff, c100p_in;
   logic [1:0]                   c100i_ff, c100i_in;
   logic                         c10p_ff, c10p_in;
   logic                         bp_prev_ff, bp_prev_in;
   logic                         c3_ff, c3_in;
   logic                         seen_b_ff, seen_b_in;
   logic                         seen_3b_ff, seen_3b_in;
   logic                         seen_bi_ff, seen_bi_in;
   logic [CMP_COUNT-1:0]         gt_ff, gt_in;

   // Output register.
   logic signed [REF_BITS-1:0]   rsp_ref_ff, rsp_ref_in;
   logic [PBIN_BITS-1:0]         rsp_pbin_ff, rsp_pbin_in;
   logic [IBIN_BITS-1:0]         rsp_ibin_ff, rsp_ibin_in;
   logic                         rsp_first_ff, rsp_first_in;

   // Control strobes from the state machine.
   logic                         load_item;
   logic                         shift_en;
   logic                         load_rsp;

   // Serial bit streams.
   logic [VOLTAGE_BITS:0]        sum_mul;
   logic                         p_bit, q_bit, c_bit, qc_bit;
   logic                         dp_bit, di_bit;
   logic [2:0]                   sum100p, sum100i;
   logic [1:0]                   sum10p, sum3b;
   logic                         dp100_bit, dp10_bit, di100_bit;
   logic                         bp_bit, bi_bit, b3_bit;
   logic                         neg_b_bit, neg_3b_bit, neg_bi_bit;
   logic                         last_bit;
   logic [CMP_COUNT-1:0]         cmp_a, cmp_b, cmp_diff, cmp_sel;

   // Finish-cycle results.
   logic [PBIN_BITS-1:0]         pbin;
   logic [IBIN_BITS-1:0]         ibin;
   logic signed [STEP_BITS-1:0]  step;
   logic signed [RW-1:0]         v_ext, min_ext, max_ext, ref_raw, ref_fin;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SHIFT;
         ST_SHIFT:  if (cnt_ff == LAST_CNT) state_in = ST_FINISH;
         ST_FINISH: if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_stall = 1'b1;
      load_item = 1'b0;
      shift_en  = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            load_item = req_valid;
         end
         ST_SHIFT: begin
            shift_en = 1'b1;
         end
         ST_FINISH: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Counter, first-sample flag and output valid.
   always_comb begin
      cnt_in       = cnt_ff;
      is_first_in  = is_first_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_item) begin
         cnt_in      = '0;
         is_first_in = 1'b0;
      end else if (shift_en) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes.
   always_comb begin
      cfg_min_in     = cfg_min_ff;
      cfg_max_in     = cfg_max_ff;
      cfg_power_in   = cfg_power_ff;
      cfg_current_in = cfg_current_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_VOLTAGE: cfg_min_in     = csr_wdata[MIN_VOLTAGE_BITS-1:0];
            CSR_MAX_VOLTAGE: cfg_max_in     = csr_wdata[MAX_VOLTAGE_BITS-1:0];
            CSR_MAX_POWER:   cfg_power_in   = csr_wdata[MAX_POWER_BITS-1:0];
            CSR_MAX_CURRENT: cfg_current_in = csr_wdata[MAX_CURRENT_BITS-1:0];
            default:         cfg_min_in     = cfg_min_ff;
         endcase
      end
   end

   // One bit of every stream for the current cycle.
   always_comb begin
      // Serial-parallel multiplier: product bits leave the accumulator LSB first.
      sum_mul = {1'b0, acc_ff} + (c_sr_ff[0] ? {1'b0, v_ff} : '0);
      p_bit   = sum_mul[0];
      c_bit   = c_sr_ff[0];
      q_bit   = (cnt_ff < PW_CNT) ? prevp_sr_ff[0] : 1'b0;
      qc_bit  = (cnt_ff < CB_CNT) ? prevc_sr_ff[0] : 1'b0;

      // Serial subtractors give the changes in two's complement. A new request
      // starts both of them with no borrow.
      dp_bit   = p_bit ^ q_bit ^ bor_p_ff;
      bor_p_in = !load_item && ((!p_bit && q_bit) || (!(p_bit ^ q_bit) && bor_p_ff));
      di_bit   = c_bit ^ qc_bit ^ bor_i_ff;
      bor_i_in = !load_item && ((!c_bit && qc_bit) || (!(c_bit ^ qc_bit) && bor_i_ff));

      // 100*x = 64x + 32x + 4x and 10*x = 8x + 2x from delayed bits.
      sum100p   = {2'b00, dph_ff[1]} + {2'b00, dph_ff[4]} + {2'b00, dph_ff[5]}
                  + {1'b0, c100p_ff};
      dp100_bit = sum100p[0];
      sum10p    = {1'b0, dph_ff[0]} + {1'b0, dph_ff[2]} + {1'b0, c10p_ff};
      dp10_bit  = sum10p[0];
      sum100i   = {2'b00, dih_ff[1]} + {2'b00, dih_ff[4]} + {2'b00, dih_ff[5]}
                  + {1'b0, c100i_ff};
      di100_bit = sum100i[0];

      // Base streams: Bp, 3*Bp, Bi and their negations.
      bp_bit     = bp_sr_ff[0];
      bi_bit     = bi_sr_ff[0];
      sum3b      = {1'b0, bp_bit} + {1'b0, bp_prev_ff} + {1'b0, c3_ff};
      b3_bit     = sum3b[0];
      neg_b_bit  = bp_bit ^ seen_b_ff;
      neg_3b_bit = b3_bit ^ seen_3b_ff;
      neg_bi_bit = bi_bit ^ seen_bi_ff;

      // Comparator operands.
      cmp_a[CMP_P_GT_NB]     = dp_bit;
      cmp_b[CMP_P_GT_NB]     = neg_b_bit;
      cmp_a[CMP_P10_GT_NB]   = dp10_bit;
      cmp_b[CMP_P10_GT_NB]   = neg_b_bit;
      cmp_a[CMP_P100_GT_N3B] = dp100_bit;
      cmp_b[CMP_P100_GT_N3B] = neg_3b_bit;
      cmp_a[CMP_P100_GT_3B]  = dp100_bit;
      cmp_b[CMP_P100_GT_3B]  = b3_bit;
      cmp_a[CMP_P10_GT_B]    = dp10_bit;
      cmp_b[CMP_P10_GT_B]    = bp_bit;
      cmp_a[CMP_P_GT_B]      = dp_bit;
      cmp_b[CMP_P_GT_B]      = bp_bit;
      cmp_a[CMP_I_GT_NB]     = di_bit;
      cmp_b[CMP_I_GT_NB]     = neg_bi_bit;
      cmp_a[CMP_I100_GT_NB]  = di100_bit;
      cmp_b[CMP_I100_GT_NB]  = neg_bi_bit;
      cmp_a[CMP_I100_GT_B]   = di100_bit;
      cmp_b[CMP_I100_GT_B]   = bi_bit;
      cmp_a[CMP_I_GT_B]      = di_bit;
      cmp_b[CMP_I_GT_B]      = bi_bit;

      // LSB-first signed compare: a differing higher bit overrides; on the sign
      // bit the operand holding a zero is the larger one.
      last_bit = (cnt_ff == LAST_CNT);
      cmp_diff = cmp_a ^ cmp_b;
      cmp_sel  = last_bit ? cmp_b : cmp_a;
   end

   // Next values of the serial datapath.
   always_comb begin
      item_first_in = item_first_ff;
      v_in          = v_ff;
      acc_in        = acc_ff;
      c_sr_in       = c_sr_ff;
      prevp_sr_in   = prevp_sr_ff;
      prevc_sr_in   = prevc_sr_ff;
      bp_sr_in      = bp_sr_ff;
      bi_sr_in      = bi_sr_ff;
      dph_in        = dph_ff;
      dih_in        = dih_ff;
      c100p_in      = c100p_ff;
      c100i_in      = c100i_ff;
      c10p_in       = c10p_ff;
      bp_prev_in    = bp_prev_ff;
      c3_in         = c3_ff;
      seen_b_in     = seen_b_ff;
      seen_3b_in    = seen_3b_ff;
      seen_bi_in    = seen_bi_ff;
      gt_in         = gt_ff;
      if (load_item) begin
         item_first_in = is_first_ff;
         v_in          = req_voltage_mv;
         acc_in        = '0;
         c_sr_in       = req_current_ma;
         bp_sr_in      = cfg_power_ff;
         bi_sr_in      = cfg_current_ff;
         dph_in        = '0;
         dih_in        = '0;
         c100p_in      = '0;
         c100i_in      = '0;
         c10p_in       = 1'b0;
         bp_prev_in    = 1'b0;
         c3_in         = 1'b0;
         seen_b_in     = 1'b0;
         seen_3b_in    = 1'b0;
         seen_bi_in    = 1'b0;
         gt_in         = '0;
      end else if (shift_en) begin
         acc_in     = sum_mul[VOLTAGE_BITS:1];
         c_sr_in    = {1'b0, c_sr_ff[CURRENT_BITS-1:1]};
         bp_sr_in   = {1'b0, bp_sr_ff[MAX_POWER_BITS-1:1]};
         bi_sr_in   = {1'b0, bi_sr_ff[MAX_CURRENT_BITS-1:1]};
         dph_in     = {dph_ff[HIST_BITS-2:0], dp_bit};
         dih_in     = {dih_ff[HIST_BITS-2:0], di_bit};
         c100p_in   = sum100p[2:1];
         c100i_in   = sum100i[2:1];
         c10p_in    = sum10p[1];
         bp_prev_in = bp_bit;
         c3_in      = sum3b[1];
         seen_b_in  = seen_b_ff || bp_bit;
         seen_3b_in = seen_3b_ff || b3_bit;
         seen_bi_in = seen_bi_ff || bi_bit;
         gt_in      = (cmp_diff & cmp_sel) | (~cmp_diff & gt_ff);
         // The new sample replaces the stored one as its bits go by.
         if (cnt_ff < PW_CNT) begin
            prevp_sr_in = {p_bit, prevp_sr_ff[PW-1:1]};
         end
         if (cnt_ff < CB_CNT) begin
            prevc_sr_in = {c_bit, prevc_sr_ff[CURRENT_BITS-1:1]};
         end
      end
   end

   // Class selection, rule step and clamp in the finish cycle.
   always_comb begin
      if (gt_ff[CMP_P_GT_NB] && !gt_ff[CMP_P10_GT_NB]) begin
         pbin = PBIN_NEG_BIG;
      end else if (gt_ff[CMP_P10_GT_NB] && !gt_ff[CMP_P100_GT_N3B]) begin
         pbin = PBIN_NEG_SMALL;
      end else if (gt_ff[CMP_P100_GT_N3B] && !gt_ff[CMP_P100_GT_3B]) begin
         pbin = PBIN_ZERO;
      end else if (gt_ff[CMP_P100_GT_3B] && !gt_ff[CMP_P10_GT_B]) begin
         pbin = PBIN_POS_SMALL;
      end else if (gt_ff[CMP_P10_GT_B] && !gt_ff[CMP_P_GT_B]) begin
         pbin = PBIN_POS_BIG;
      end else begin
         pbin = PBIN_ZERO;
      end

      if (gt_ff[CMP_I_GT_NB] && !gt_ff[CMP_I100_GT_NB]) begin
         ibin = IBIN_NEG;
      end else if (gt_ff[CMP_I100_GT_NB] && !gt_ff[CMP_I100_GT_B]) begin
         ibin = IBIN_ZERO;
      end else if (gt_ff[CMP_I100_GT_B] && !gt_ff[CMP_I_GT_B]) begin
         ibin = IBIN_POS;
      end else begin
         ibin = IBIN_ZERO;
      end

      step    = rule_step(ibin, pbin);
      v_ext   = $signed(RW'(v_ff));
      min_ext = $signed(RW'(cfg_min_ff));
      max_ext = $signed(RW'(cfg_max_ff));
      ref_raw = item_first_ff ? min_ext : (v_ext + RW'(step));
      ref_fin = (ref_raw >= max_ext) ? (max_ext - RW'(CLAMP_MARGIN_MV)) : ref_raw;

      rsp_ref_in   = rsp_ref_ff;
      rsp_pbin_in  = rsp_pbin_ff;
      rsp_ibin_in  = rsp_ibin_ff;
      rsp_first_in = rsp_first_ff;
      if (load_rsp) begin
         rsp_ref_in   = ref_fin[REF_BITS-1:0];
         rsp_pbin_in  = item_first_ff ? PBIN_ZERO : pbin;
         rsp_ibin_in  = item_first_ff ? IBIN_ZERO : ibin;
         rsp_first_in = item_first_ff;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         is_first_ff    <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         cfg_min_ff     <= RESET_MIN_VOLTAGE;
         cfg_max_ff     <= RESET_MAX_VOLTAGE;
         cfg_power_ff   <= RESET_MAX_POWER;
         cfg_current_ff <= RESET_MAX_CURRENT;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         is_first_ff    <= is_first_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_min_ff     <= cfg_min_in;
         cfg_max_ff     <= cfg_max_in;
         cfg_power_ff   <= cfg_power_in;
         cfg_current_ff <= cfg_current_in;
      end
   end

   // Datapath and output payload registers.
   always_ff @(posedge clock) begin
      item_first_ff <= item_first_in;
      v_ff          <= v_in;
      acc_ff        <= acc_in;
      c_sr_ff       <= c_sr_in;
      prevp_sr_ff   <= prevp_sr_in;
      prevc_sr_ff   <= prevc_sr_in;
      bp_sr_ff      <= bp_sr_in;
      bi_sr_ff      <= bi_sr_in;
      bor_p_ff      <= bor_p_in;
      bor_i_ff      <= bor_i_in;
      dph_ff        <= dph_in;
      dih_ff        <= dih_in;
      c100p_ff      <= c100p_in;
      c100i_ff      <= c100i_in;
      c10p_ff       <= c10p_in;
      bp_prev_ff    <= bp_prev_in;
      c3_ff         <= c3_in;
      seen_b_ff     <= seen_b_in;
      seen_3b_ff    <= seen_3b_in;
      seen_bi_ff    <= seen_bi_in;
      gt_ff         <= gt_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_pbin_ff   <= rsp_pbin_in;
      rsp_ibin_ff   <= rsp_ibin_in;
      rsp_first_ff  <= rsp_first_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ref_voltage_mv = rsp_ref_ff;
   assign rsp_power_bin      = rsp_pbin_ff;
   assign rsp_current_bin    = rsp_ibin_ff;
   assign rsp_first_sample   = rsp_first_ff;

`ifndef SYNTHESIS
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !is_first_ff)
      else $error("first-sample flag still set after a request");

   a_first_bins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_sample) |->
         (rsp_power_bin == PBIN_ZERO && rsp_current_bin == IBIN_ZERO))
      else $error("first sample carries a non-middle class");

   a_pass_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && cnt_ff == LAST_CNT) |=> (state_ff == ST_FINISH))
      else $error("serial pass did not end after its last bit");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid && rsp_stall) |=>
         (state_ff == ST_FINISH && rsp_valid))
      else $error("finished result dropped while the output was occupied");
`endif

endmodule
